>>> src/multi_priority_task_ring_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority task ring queue
// Implication checks that compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_PRIORITY_TASK_RING_QUEUE_MACROS_SVH
`define MULTI_PRIORITY_TASK_RING_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MPTRQ_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mptrq assertion failed");
// next-cycle implication
`define MPTRQ_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mptrq assertion failed");
`else
`define MPTRQ_ASSERT_IMP(label, clk, rst, a, b)
`define MPTRQ_ASSERT_NXT(label, clk, rst, a, b)
`endif

`endif

>>> src/mptrq_pkg.sv
// ----------------------------------------------------------------------------
// mptrq_pkg
// Sizes, status codes and control structs of the priority task ring queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mptrq_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int DEPTH      = 16;

  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int SLOTS   = NUM_LEVELS * DEPTH;
  localparam int SLOT_W  = $clog2(SLOTS);

  localparam int PRIO_W  = 2;
  localparam int ADDR_W  = 48;
  localparam int ARG_W   = 64;
  localparam int DESC_W  = 2 * ADDR_W + 2 * ARG_W;
  localparam int FIELD_W = PRIO_W + DESC_W;
  localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic exec;     // update pointers, access the ring memory
    logic load;     // move the result into the output register
  } mptrq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // output register empty or being drained
  } mptrq_stat_t;

endpackage

>>> src/mptrq_ctrl.sv
// ----------------------------------------------------------------------------
// mptrq_ctrl
// Sequencer: accept a request, execute it, hand the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mptrq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  mptrq_pkg::mptrq_stat_t stat,
  output mptrq_pkg::mptrq_cmd_t  cmd
);
  import mptrq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  always_comb begin
    s_tready = (state == S_IDLE) || ((state == S_DONE) && stat.out_free);
  end

  assign accept = s_tvalid && s_tready;

  always_comb begin
    cmd.capture = accept;
    cmd.exec    = (state == S_EXEC);
    cmd.load    = (state == S_DONE) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        // take the next request in the same cycle the result leaves
        if (accept) state_next = S_EXEC;
        else if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/mptrq_dp.sv
// ----------------------------------------------------------------------------
// mptrq_dp
// Ring pointers, drain scan, descriptor memory and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mptrq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mptrq_pkg::mptrq_cmd_t             cmd,
  output mptrq_pkg::mptrq_stat_t            stat,
  input  logic [mptrq_pkg::TDATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mptrq_pkg::TDATA_W-1:0]     m_tdata,
  output logic [mptrq_pkg::STAT_W-1:0]      m_tuser
);
  import mptrq_pkg::*;

  // latched request
  logic              op_r;
  logic [PRIO_W-1:0] prio_r;
  logic [DESC_W-1:0] desc_r;

  logic [PTR_W-1:0]  rp [NUM_LEVELS];
  logic [PTR_W-1:0]  wp [NUM_LEVELS];
  logic [LVL_W-1:0]  scan_level;
  logic              taken;

  logic [STAT_W-1:0] res_status;
  logic [PRIO_W-1:0] res_prio;

  logic [DESC_W-1:0] mem [SLOTS];
  logic [DESC_W-1:0] rd_data;

  logic [NUM_LEVELS-1:0] nonempty;
  logic              found_a, found_b;
  logic [LVL_W-1:0]  lvl_a, lvl_b;
  logic              hit;
  logic [LVL_W-1:0]  hit_lvl;
  logic [LVL_W-1:0]  enq_lvl;
  logic              enq_bad;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;
  logic              enq_full;
  logic              do_write, do_read;
  logic [SLOT_W-1:0] waddr, raddr;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= s_tuser;
      prio_r <= s_tdata[PRIO_W-1:0];
      desc_r <= s_tdata[FIELD_W-1:PRIO_W];
    end
  end

  // drain scan over the occupancy flags
  always_comb begin
    found_a = 1'b0;
    found_b = 1'b0;
    lvl_a   = '0;
    lvl_b   = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (rp[l] != wp[l]);
      if (nonempty[l]) begin
        found_b = 1'b1;
        lvl_b   = LVL_W'(l);
        if (LVL_W'(l) <= scan_level) begin
          found_a = 1'b1;
          lvl_a   = LVL_W'(l);
        end
      end
    end
    // restart from the top only if something was taken in this pass
    hit     = found_a || (taken && found_b);
    hit_lvl = found_a ? lvl_a : lvl_b;
  end

  always_comb begin
    enq_bad  = (int'(prio_r) >= NUM_LEVELS);
    enq_lvl  = LVL_W'(prio_r);
    wp_adv   = advance(wp[enq_lvl]);
    rp_adv   = advance(rp[hit_lvl]);
    enq_full = enq_bad || (wp_adv == rp[enq_lvl]);
    do_write = cmd.exec && (op_r == OP_ENQUEUE) && !enq_full;
    do_read  = cmd.exec && (op_r == OP_REQUEST) && hit;
    waddr    = SLOT_W'(enq_lvl) * SLOT_W'(DEPTH) + SLOT_W'(wp[enq_lvl]);
    raddr    = SLOT_W'(hit_lvl) * SLOT_W'(DEPTH) + SLOT_W'(rp[hit_lvl]);
  end

  always_ff @(posedge clk) begin
    if (do_write) mem[waddr] <= desc_r;
    if (do_read) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        rp[l] <= '0;
        wp[l] <= '0;
      end
      scan_level <= LVL_W'(NUM_LEVELS - 1);
      taken      <= 1'b0;
    end else if (cmd.exec) begin
      if (op_r == OP_ENQUEUE) begin
        if (!enq_full) wp[enq_lvl] <= wp_adv;
      end else if (hit) begin
        rp[hit_lvl] <= rp_adv;
        scan_level  <= hit_lvl;
        taken       <= 1'b1;
      end else begin
        scan_level <= LVL_W'(NUM_LEVELS - 1);
        taken      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_prio <= PRIO_W'(hit_lvl);
      if (op_r == OP_ENQUEUE) res_status <= enq_full ? ST_DROPPED : ST_ENQUEUED;
      else res_status <= hit ? ST_DEQUEUED : ST_EMPTY;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tuser <= res_status;
      if (res_status == ST_DEQUEUED) begin
        m_tdata <= TDATA_W'({rd_data, res_prio});
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

>>> src/multi_priority_task_ring_queue.sv
// ----------------------------------------------------------------------------
// multi_priority_task_ring_queue
// Priority task queue: one descriptor ring per level, drain scan.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tuser: operation; tdata: priority, handler, arg1, arg2, unmask
//  m_*      out  tuser: status; tdata: priority, handler, arg1, arg2, unmask
//
//  A request is executed in S_EXEC, which updates the ring pointers and
//  accesses the descriptor memory (single write or registered read port);
//  S_DONE then loads the output register as it accepts the next request.
//  Reset is synchronous; no clearing pass, the memory is read only where
//  written. A full output register holds the block until m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_priority_task_ring_queue_macros.svh"

module multi_priority_task_ring_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // priority[1:0], handler[49:2], first arg[113:50], second arg[177:114],
  // unmask[225:178], zero fill
  input  logic [mptrq_pkg::TDATA_W-1:0] s_tdata,
  // operation[0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // priority[1:0], handler[49:2], first arg[113:50], second arg[177:114],
  // unmask[225:178], zero fill
  output logic [mptrq_pkg::TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [mptrq_pkg::STAT_W-1:0]  m_tuser
);
  import mptrq_pkg::*;

  mptrq_cmd_t  cmd;
  mptrq_stat_t stat;

  mptrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mptrq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `MPTRQ_ASSERT_NXT(a_accept_exec, clk, rst, s_tvalid && s_tready, cmd.exec)
  `MPTRQ_ASSERT_IMP(a_no_accept_in_exec, clk, rst, cmd.exec, !s_tready)
  `MPTRQ_ASSERT_IMP(a_load_free, clk, rst, cmd.load, !m_tvalid || m_tready)
  `MPTRQ_ASSERT_NXT(a_load_valid, clk, rst, cmd.load, m_tvalid)

endmodule

>>> sim/multi_priority_task_ring_queue_tb.sv
// ----------------------------------------------------------------------------
// multi_priority_task_ring_queue_tb
// Streams enqueue and next-task requests into the priority task queue and
// checks every result against a cycle-free copy of the rings and drain scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_priority_task_ring_queue_tb;
  import mptrq_pkg::*;

  localparam int RANDOM_REQS = 1700;
  localparam int MIX_FILL    = 0;
  localparam int MIX_DRAIN   = 1;
  localparam int MIX_EVEN    = 2;

  // first field in the lowest bits, as on the bus
  typedef struct packed {
    logic [ADDR_W-1:0] unmask;
    logic [ARG_W-1:0]  arg2;
    logic [ARG_W-1:0]  arg1;
    logic [ADDR_W-1:0] handler;
    logic [PRIO_W-1:0] prio;
  } task_desc_t;

  typedef struct {
    logic       op;
    task_desc_t desc;
    bit         hold;
    int         phase;
  } task_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    task_desc_t        desc;
  } task_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = OP_ENQUEUE;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]  m_tuser;

  task_req_t    task_reqs[$];
  task_answer_t answers_due[$];
  task_req_t    in_flight;
  int           accepted_count = 0;
  int           total_reqs = 0;
  int           error_count = 0;
  int           idle_phase = 0;
  int           send_idle_pct[3] = '{10, 85, 0};
  int           recv_idle_pct[3] = '{85, 10, 0};

  // predictor state
  logic [PTR_W-1:0] head_ptr[NUM_LEVELS];
  logic [PTR_W-1:0] tail_ptr[NUM_LEVELS];
  task_desc_t       ring_slots[NUM_LEVELS][DEPTH];
  logic [LVL_W-1:0] scan_lvl;
  logic             drained_in_pass;

  multi_priority_task_ring_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // highest non-empty level at or below 'from', -1 if none
  function automatic int first_ready(int from);
    for (int lv = from; lv >= 0; lv--) begin
      if (head_ptr[lv] != tail_ptr[lv]) return lv;
    end
    return -1;
  endfunction

  function automatic task_answer_t serve_request(task_req_t r);
    task_answer_t     ans;
    int               lvl;
    logic [PTR_W-1:0] nxt;
    ans = '0;
    if (r.op == OP_ENQUEUE) begin
      lvl = int'(r.desc.prio);
      if (lvl >= NUM_LEVELS) begin
        ans.status = ST_DROPPED;
        return ans;
      end
      nxt = PTR_W'((int'(tail_ptr[lvl]) + 1) % DEPTH);
      if (nxt == head_ptr[lvl]) begin
        ans.status = ST_DROPPED;
      end else begin
        ring_slots[lvl][tail_ptr[lvl]] = r.desc;
        tail_ptr[lvl] = nxt;
        ans.status = ST_ENQUEUED;
      end
      return ans;
    end
    lvl = first_ready(int'(scan_lvl));
    // restart from the top only once per pass
    if (lvl < 0 && drained_in_pass) begin
      scan_lvl = LVL_W'(NUM_LEVELS - 1);
      drained_in_pass = 1'b0;
      lvl = first_ready(NUM_LEVELS - 1);
    end
    if (lvl < 0) begin
      scan_lvl = LVL_W'(NUM_LEVELS - 1);
      drained_in_pass = 1'b0;
      ans.status = ST_EMPTY;
      return ans;
    end
    ans.status = ST_DEQUEUED;
    ans.desc = ring_slots[lvl][head_ptr[lvl]];
    ans.desc.prio = PRIO_W'(lvl);
    head_ptr[lvl] = PTR_W'((int'(head_ptr[lvl]) + 1) % DEPTH);
    scan_lvl = LVL_W'(lvl);
    drained_in_pass = 1'b1;
    return ans;
  endfunction

  task automatic report_error(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [ARG_W-1:0] got, logic [ARG_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  function automatic logic [ARG_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic task_desc_t make_desc(int prio, logic [ARG_W-1:0] h, logic [ARG_W-1:0] a1,
                                           logic [ARG_W-1:0] a2, logic [ARG_W-1:0] u);
    task_desc_t d;
    d.prio    = PRIO_W'(prio);
    d.handler = ADDR_W'(h);
    d.arg1    = a1;
    d.arg2    = a2;
    d.unmask  = ADDR_W'(u);
    return d;
  endfunction

  task automatic push_req(logic op, task_desc_t d);
    task_req_t r;
    r.op    = op;
    r.desc  = d;
    r.hold  = 1'b0;
    r.phase = 0;
    task_reqs.push_back(r);
  endtask

  // driver: present the next pending request, predict it on acceptance
  always @(posedge clk) begin : driver
    logic next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      foreach (head_ptr[i]) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
      end
      scan_lvl = LVL_W'(NUM_LEVELS - 1);
      drained_in_pass = 1'b0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        answers_due.push_back(serve_request(in_flight));
        accepted_count++;
        next_valid = 1'b0;
      end
      if (!next_valid && task_reqs.size() != 0) begin
        if (!(task_reqs[0].hold && answers_due.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[task_reqs[0].phase]) begin
          in_flight = task_reqs.pop_front();
          next_valid = 1'b1;
          s_tdata <= TDATA_W'(in_flight.desc);
          s_tuser <= in_flight.op;
          idle_phase <= in_flight.phase;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : monitor
    task_answer_t want;
    task_desc_t   got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = task_desc_t'(m_tdata[FIELD_W-1:0]);
        if (answers_due.size() == 0) begin
          report_error($sformatf("unexpected result, status %0d", m_tuser));
        end else begin
          want = answers_due.pop_front();
          compare_field("status", ARG_W'(m_tuser), ARG_W'(want.status));
          compare_field("priority", ARG_W'(got.prio), ARG_W'(want.desc.prio));
          compare_field("handler", ARG_W'(got.handler), ARG_W'(want.desc.handler));
          compare_field("first arg", got.arg1, want.desc.arg1);
          compare_field("second arg", got.arg2, want.desc.arg2);
          compare_field("unmask", ARG_W'(got.unmask), ARG_W'(want.desc.unmask));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
    end
  end

  initial begin : stimulus
    int seg_len;
    int mix;
    int focus;
    int enq_pct;
    int p;
    int directed;
    logic op;

    // empty answer right after reset
    push_req(OP_REQUEST, make_desc(0, '1, '1, '1, '1));
    push_req(OP_ENQUEUE, make_desc(0, '0, '0, '0, '0));
    push_req(OP_ENQUEUE, make_desc(3, '1, '1, '1, '1));
    push_req(OP_ENQUEUE, make_desc(1, {32{2'b10}}, {32{2'b10}}, {32{2'b01}}, {32{2'b01}}));
    push_req(OP_REQUEST, make_desc(0, '0, '0, '0, '0));
    push_req(OP_REQUEST, make_desc(3, '0, '0, '0, '0));
    // lands above the scan level: served only after the restart
    push_req(OP_ENQUEUE, make_desc(2, {32{2'b01}}, {32{2'b01}}, {32{2'b10}}, {32{2'b10}}));
    push_req(OP_REQUEST, make_desc(1, pick_word(), pick_word(), pick_word(), pick_word()));
    push_req(OP_REQUEST, make_desc(2, pick_word(), pick_word(), pick_word(), pick_word()));
    push_req(OP_REQUEST, make_desc(3, pick_word(), pick_word(), pick_word(), pick_word()));
    // fill one ring past capacity, last one dropped
    repeat (DEPTH) begin
      push_req(OP_ENQUEUE, make_desc(2, pick_word(), pick_word(), pick_word(), pick_word()));
    end
    directed = task_reqs.size();

    // segments biased toward filling, draining or neither, mostly on one level
    while (task_reqs.size() < directed + RANDOM_REQS) begin
      seg_len = $urandom_range(40, 8);
      mix = $urandom_range(MIX_EVEN, MIX_FILL);
      focus = $urandom_range(NUM_LEVELS - 1);
      enq_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 25 : 55;
      repeat (seg_len) begin
        p = ($urandom_range(99) < 60) ? focus : $urandom_range(3);
        op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_REQUEST;
        push_req(op, make_desc(p, pick_word(), pick_word(), pick_word(), pick_word()));
      end
    end
    total_reqs = task_reqs.size();

    foreach (task_reqs[i]) begin
      task_reqs[i].phase = (i * 3) / total_reqs;
      task_reqs[i].hold = (i == total_reqs / 3) || (i == (2 * total_reqs) / 3) ||
                          ($urandom_range(99) < 2);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_reqs) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // far beyond the slowest legal run of all requests
  initial begin : watchdog
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
